// File: src/assert_macros.svh
// Assertion macros shared by the calendar/seconds converter RTL.
// Depends on nothing; the including module supplies clk and rst_n.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled while reset is held.
`define CSC_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, disabled while reset is held.
`define CSC_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// File: src/csc_pkg.sv
// Package for the calendar/seconds converter: item types, constants, month tables.
// Depends on nothing; used by csc_month_find and calendar_seconds_converter_unit.
`default_nettype none

package csc_pkg;

  localparam logic [31:0] UNIX_OFFSET = 32'd946684800;
  localparam logic [31:0] SECONDS_MAX = 32'd3155759999;
  localparam logic [31:0] SEC_PER_DAY = 32'd86400;

  // Reciprocal constants: floor(x / d) == (x * RECIP) >> SHIFT over the value range used.
  localparam logic [25:0] DAY_RECIP   = 26'd50903317;  // x / 675, x < 2^25
  localparam int          DAY_SHIFT   = 35;
  localparam logic [17:0] HOUR_RECIP  = 18'd149131;    // x / 3600, x < 86400
  localparam int          HOUR_SHIFT  = 29;
  localparam logic [12:0] MIN_RECIP   = 13'd4370;      // x / 60, x < 3600
  localparam int          MIN_SHIFT   = 18;
  localparam logic [16:0] WEEK_RECIP  = 17'd74899;     // x / 7, x < 2^16 + 8
  localparam int          WEEK_SHIFT  = 19;
  localparam logic [16:0] QUAD_RECIP  = 17'd91868;     // x / 1461, x < 36525
  localparam int          QUAD_SHIFT  = 27;

  typedef struct packed {
    logic        func;
    logic [6:0]  year_in;
    logic [3:0]  month_in;
    logic [4:0]  day_in;
    logic [4:0]  hour_in;
    logic [5:0]  minute_in;
    logic [5:0]  second_in;
    logic [31:0] seconds_in;
  } csc_in_t;

  typedef struct packed {
    logic [31:0] seconds_out;
    logic [31:0] unix_seconds;
    logic [6:0]  year_out;
    logic [3:0]  month_out;
    logic [4:0]  day_out;
    logic [4:0]  hour_out;
    logic [5:0]  minute_out;
    logic [5:0]  second_out;
    logic [2:0]  weekday;
    logic        range_error;
  } csc_out_t;

  // Days in the year before the first of a month.
  function automatic logic [8:0] month_start(input logic [3:0] mon, input logic leap);
    logic [8:0] base;
    unique case (mon)
      4'd1:    base = 9'd0;
      4'd2:    base = 9'd31;
      4'd3:    base = 9'd59;
      4'd4:    base = 9'd90;
      4'd5:    base = 9'd120;
      4'd6:    base = 9'd151;
      4'd7:    base = 9'd181;
      4'd8:    base = 9'd212;
      4'd9:    base = 9'd243;
      4'd10:   base = 9'd273;
      4'd11:   base = 9'd304;
      4'd12:   base = 9'd334;
      default: base = 9'd0;
    endcase
    if (leap && mon > 4'd2) begin
      base = base + 9'd1;
    end
    return base;
  endfunction

  // Length of a month; zero for a month number that means nothing.
  function automatic logic [4:0] month_days(input logic [3:0] mon, input logic leap);
    logic [4:0] len;
    unique case (mon)
      4'd1, 4'd3, 4'd5, 4'd7, 4'd8, 4'd10, 4'd12: len = 5'd31;
      4'd4, 4'd6, 4'd9, 4'd11:                    len = 5'd30;
      4'd2:                                        len = leap ? 5'd29 : 5'd28;
      default:                                     len = 5'd0;
    endcase
    return len;
  endfunction

endpackage

`default_nettype wire

// File: src/csc_month_find.sv
// Month search: splits a day of the year into month and day of month.
// Depends on csc_pkg (month_start).
`default_nettype none

module csc_month_find (
  input  wire logic [8:0] doy,
  input  wire logic       leap,
  output logic      [3:0] mon,
  output logic      [4:0] day
);
  import csc_pkg::*;

  logic [8:0] start;

  // Compare against every month start at once; the last one passed wins.
  always_comb begin
    mon = 4'd1;
    for (int k = 2; k <= 12; k++) begin
      if (doy >= month_start(4'(k), leap)) begin
        mon = 4'(k);
      end
    end
  end

  assign start = month_start(mon, leap);
  assign day   = 5'(doy - start + 9'd1);

endmodule

`default_nettype wire

// File: src/calendar_seconds_converter_unit.sv
// Top level of the calendar/seconds converter: seven-stage pipeline, both directions.
// Depends on csc_pkg, csc_month_find and assert_macros.svh.
//
//   channel | ports                          | payload
//   --------+--------------------------------+-------------------
//   input   | in_valid, in_ready, in_data    | csc_pkg::csc_in_t
//   result  | out_valid, out_ready, out_data | csc_pkg::csc_out_t
//
// One item enters per cycle while no result is held at the output; each item then moves
// through stages A through F and the output register, which are seven registers, and stage A
// loads on the accepting edge.
// Reset (rst_n low at a clock edge) clears only the stage valid bits.
// When a result is held at the output, every stage holds; nothing is lost or repeated.
// Divisions by constants are reciprocal multiplies, at most two of them in any stage.
`default_nettype none
`include "assert_macros.svh"

module calendar_seconds_converter_unit (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              in_valid,
  output logic                   in_ready,
  input  wire csc_pkg::csc_in_t  in_data,
  output logic                   out_valid,
  input  wire logic              out_ready,
  output csc_pkg::csc_out_t      out_data
);
  import csc_pkg::*;

  // Date and time fields carried along for the date-to-seconds direction.
  typedef struct packed {
    logic [6:0] yr;
    logic [3:0] mon;
    logic [4:0] day;
    logic [4:0] hr;
    logic [5:0] mi;
    logic [5:0] se;
  } date_t;

  localparam int STAGES = 7;

  logic                pipe_en;
  logic [STAGES-1:0]   vld_r;
  logic [STAGES-1:0]   vld_nxt;

  // ---------------------------------------------------------------- stage A
  // Validate both modes, build the day count of a given date, start the day divide.
  logic        a_leap;
  logic        a_err_nxt;
  logic [15:0] a_yr16;
  logic [15:0] a_days_nxt;
  logic [16:0] a_tod_nxt;
  logic [50:0] a_dprod_nxt;
  date_t       a_date_nxt;

  logic        a_func_r;
  logic        a_err_r;
  logic [15:0] a_days_r;
  logic [16:0] a_tod_r;
  logic [31:0] a_t_r;
  logic [50:0] a_dprod_r;
  date_t       a_date_r;

  assign a_leap = (in_data.year_in[1:0] == 2'b00);
  assign a_yr16 = {9'b0, in_data.year_in};

  always_comb begin
    if (in_data.func) begin
      a_err_nxt = (in_data.seconds_in > SECONDS_MAX);
    end else begin
      a_err_nxt = (in_data.year_in > 7'd99) || (in_data.month_in < 4'd1) ||
                  (in_data.month_in > 4'd12) || (in_data.hour_in > 5'd23) ||
                  (in_data.minute_in > 6'd59) || (in_data.second_in > 6'd59) ||
                  (in_data.day_in == 5'd0) ||
                  (in_data.day_in > month_days(in_data.month_in, a_leap));
    end
  end

  // Days since the epoch: 365 per year plus one per leap year already passed, then the days of the year.
  assign a_days_nxt = a_yr16 * 16'd365 + ((a_yr16 + 16'd3) >> 2) +
                      {7'b0, month_start(in_data.month_in, a_leap)} +
                      {11'b0, in_data.day_in} - 16'd1;
  assign a_tod_nxt  = {12'b0, in_data.hour_in} * 17'd3600 +
                      {11'b0, in_data.minute_in} * 17'd60 + {11'b0, in_data.second_in};
  // seconds / 86400 == (seconds / 128) / 675
  assign a_dprod_nxt = 51'(in_data.seconds_in[31:7]) * 51'(DAY_RECIP);
  assign a_date_nxt  = '{yr: in_data.year_in, mon: in_data.month_in, day: in_data.day_in,
                         hr: in_data.hour_in, mi: in_data.minute_in, se: in_data.second_in};

  always_ff @(posedge clk) begin
    if (pipe_en) begin
      a_func_r  <= in_data.func;
      a_err_r   <= a_err_nxt;
      a_days_r  <= a_days_nxt;
      a_tod_r   <= a_tod_nxt;
      a_t_r     <= in_data.seconds_in;
      a_dprod_r <= a_dprod_nxt;
      a_date_r  <= a_date_nxt;
    end
  end

  // ---------------------------------------------------------------- stage B
  // Pick the day count, then scale it to seconds and start the weekday and 4-year divides.
  logic [15:0] b_days_nxt;
  logic [16:0] b_wx;
  logic [31:0] b_dsec_nxt;
  logic [33:0] b_wprod_nxt;
  logic [32:0] b_qprod_nxt;

  logic        b_func_r;
  logic        b_err_r;
  logic [15:0] b_days_r;
  logic [31:0] b_dsec_r;
  logic [33:0] b_wprod_r;
  logic [32:0] b_qprod_r;
  logic [16:0] b_tod_r;
  logic [31:0] b_t_r;
  date_t       b_date_r;

  assign b_days_nxt  = a_func_r ? a_dprod_r[DAY_SHIFT +: 16] : a_days_r;
  assign b_wx        = {1'b0, b_days_nxt} + 17'd6;    // day 0 was a Saturday
  assign b_dsec_nxt  = {16'b0, b_days_nxt} * SEC_PER_DAY;
  assign b_wprod_nxt = 34'(b_wx) * 34'(WEEK_RECIP);
  assign b_qprod_nxt = 33'(b_days_nxt) * 33'(QUAD_RECIP);

  always_ff @(posedge clk) begin
    if (pipe_en) begin
      b_func_r  <= a_func_r;
      b_err_r   <= a_err_r;
      b_days_r  <= b_days_nxt;
      b_dsec_r  <= b_dsec_nxt;
      b_wprod_r <= b_wprod_nxt;
      b_qprod_r <= b_qprod_nxt;
      b_tod_r   <= a_tod_r;
      b_t_r     <= a_t_r;
      b_date_r  <= a_date_r;
    end
  end

  // ---------------------------------------------------------------- stage C
  // Seconds of the day, final seconds count, quotients of the two divides.
  logic [16:0] c_sod_nxt;
  logic [31:0] c_secs_nxt;

  logic        c_func_r;
  logic        c_err_r;
  logic [15:0] c_days_r;
  logic [16:0] c_sod_r;
  logic [31:0] c_secs_r;
  logic [12:0] c_wq_r;
  logic [4:0]  c_q4_r;
  date_t       c_date_r;

  assign c_sod_nxt  = 17'(b_t_r - b_dsec_r);
  assign c_secs_nxt = b_func_r ? b_t_r : (b_dsec_r + {15'b0, b_tod_r});

  always_ff @(posedge clk) begin
    if (pipe_en) begin
      c_func_r <= b_func_r;
      c_err_r  <= b_err_r;
      c_days_r <= b_days_r;
      c_sod_r  <= c_sod_nxt;
      c_secs_r <= c_secs_nxt;
      c_wq_r   <= b_wprod_r[WEEK_SHIFT +: 13];
      c_q4_r   <= b_qprod_r[QUAD_SHIFT +: 5];
      c_date_r <= b_date_r;
    end
  end

  // ---------------------------------------------------------------- stage D
  // Weekday and day within the 4-year block; start the hour divide.
  logic [16:0] d_wd_full;
  logic [15:0] d_r4_full;
  logic [34:0] d_hprod_nxt;

  logic        d_func_r;
  logic        d_err_r;
  logic [16:0] d_sod_r;
  logic [31:0] d_secs_r;
  logic [2:0]  d_wd_r;
  logic [10:0] d_r4_r;
  logic [4:0]  d_q4_r;
  logic [34:0] d_hprod_r;
  date_t       d_date_r;

  assign d_wd_full   = ({1'b0, c_days_r} + 17'd6) - {4'b0, c_wq_r} * 17'd7;
  assign d_r4_full   = c_days_r - {11'b0, c_q4_r} * 16'd1461;
  assign d_hprod_nxt = 35'(c_sod_r) * 35'(HOUR_RECIP);

  always_ff @(posedge clk) begin
    if (pipe_en) begin
      d_func_r  <= c_func_r;
      d_err_r   <= c_err_r;
      d_sod_r   <= c_sod_r;
      d_secs_r  <= c_secs_r;
      d_wd_r    <= d_wd_full[2:0];
      d_r4_r    <= d_r4_full[10:0];
      d_q4_r    <= c_q4_r;
      d_hprod_r <= d_hprod_nxt;
      d_date_r  <= c_date_r;
    end
  end

  // ---------------------------------------------------------------- stage E
  // Hour, seconds within the hour, year and day of the year.
  logic [4:0]  e_hr_nxt;
  logic [16:0] e_ms_full;
  logic [1:0]  e_yoff;
  logic [10:0] e_ystart;
  logic [10:0] e_doy_full;

  logic        e_func_r;
  logic        e_err_r;
  logic [31:0] e_secs_r;
  logic [2:0]  e_wd_r;
  logic [4:0]  e_hr_r;
  logic [11:0] e_ms_r;
  logic [6:0]  e_yr_r;
  logic        e_leap_r;
  logic [8:0]  e_doy_r;
  date_t       e_date_r;

  assign e_hr_nxt  = d_hprod_r[HOUR_SHIFT +: 5];
  assign e_ms_full = d_sod_r - {12'b0, e_hr_nxt} * 17'd3600;

  // The first year of each 4-year block is the leap year.
  always_comb begin
    priority if (d_r4_r >= 11'd1096) begin
      e_yoff = 2'd3;  e_ystart = 11'd1096;
    end else if (d_r4_r >= 11'd731) begin
      e_yoff = 2'd2;  e_ystart = 11'd731;
    end else if (d_r4_r >= 11'd366) begin
      e_yoff = 2'd1;  e_ystart = 11'd366;
    end else begin
      e_yoff = 2'd0;  e_ystart = 11'd0;
    end
  end

  assign e_doy_full = d_r4_r - e_ystart;

  always_ff @(posedge clk) begin
    if (pipe_en) begin
      e_func_r <= d_func_r;
      e_err_r  <= d_err_r;
      e_secs_r <= d_secs_r;
      e_wd_r   <= d_wd_r;
      e_hr_r   <= e_hr_nxt;
      e_ms_r   <= e_ms_full[11:0];
      e_yr_r   <= {d_q4_r, e_yoff};
      e_leap_r <= (e_yoff == 2'd0);
      e_doy_r  <= e_doy_full[8:0];
      e_date_r <= d_date_r;
    end
  end

  // ---------------------------------------------------------------- stage F
  // Month and day of month; start the minute divide.
  logic [3:0]  f_mon_nxt;
  logic [4:0]  f_day_nxt;
  logic [24:0] f_mprod_nxt;

  logic        f_func_r;
  logic        f_err_r;
  logic [31:0] f_secs_r;
  logic [2:0]  f_wd_r;
  logic [4:0]  f_hr_r;
  logic [11:0] f_ms_r;
  logic [24:0] f_mprod_r;
  logic [6:0]  f_yr_r;
  logic [3:0]  f_mon_r;
  logic [4:0]  f_day_r;
  date_t       f_date_r;

  csc_month_find u_month_find (
    .doy  (e_doy_r),
    .leap (e_leap_r),
    .mon  (f_mon_nxt),
    .day  (f_day_nxt)
  );

  assign f_mprod_nxt = 25'(e_ms_r) * 25'(MIN_RECIP);

  always_ff @(posedge clk) begin
    if (pipe_en) begin
      f_func_r  <= e_func_r;
      f_err_r   <= e_err_r;
      f_secs_r  <= e_secs_r;
      f_wd_r    <= e_wd_r;
      f_hr_r    <= e_hr_r;
      f_ms_r    <= e_ms_r;
      f_mprod_r <= f_mprod_nxt;
      f_yr_r    <= e_yr_r;
      f_mon_r   <= f_mon_nxt;
      f_day_r   <= f_day_nxt;
      f_date_r  <= e_date_r;
    end
  end

  // ---------------------------------------------------------------- output register
  // Minute and second, then merge the two modes; an error item drops all other fields to zero.
  logic [5:0]  g_mi;
  logic [11:0] g_se_full;
  csc_out_t    out_nxt;
  csc_out_t    out_r;

  assign g_mi      = f_mprod_r[MIN_SHIFT +: 6];
  assign g_se_full = f_ms_r - {6'b0, g_mi} * 12'd60;

  always_comb begin
    out_nxt = '0;
    if (f_err_r) begin
      out_nxt.range_error = 1'b1;
    end else begin
      out_nxt.seconds_out  = f_secs_r;
      out_nxt.unix_seconds = f_secs_r + UNIX_OFFSET;
      out_nxt.weekday      = f_wd_r;
      if (f_func_r) begin
        out_nxt.year_out   = f_yr_r;
        out_nxt.month_out  = f_mon_r;
        out_nxt.day_out    = f_day_r;
        out_nxt.hour_out   = f_hr_r;
        out_nxt.minute_out = g_mi;
        out_nxt.second_out = g_se_full[5:0];
      end else begin
        out_nxt.year_out   = f_date_r.yr;
        out_nxt.month_out  = f_date_r.mon;
        out_nxt.day_out    = f_date_r.day;
        out_nxt.hour_out   = f_date_r.hr;
        out_nxt.minute_out = f_date_r.mi;
        out_nxt.second_out = f_date_r.se;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (pipe_en) begin
      out_r <= out_nxt;
    end
  end

  // ---------------------------------------------------------------- flow control
  // Advance the whole pipeline unless a result waits at the output; hold everything otherwise.
  assign pipe_en = !vld_r[STAGES-1] || out_ready;
  assign vld_nxt = {vld_r[STAGES-2:0], in_valid && pipe_en};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else if (pipe_en) begin
      vld_r <= vld_nxt;
    end
  end

  assign in_ready  = pipe_en;
  assign out_valid = vld_r[STAGES-1];
  assign out_data  = out_r;

  // ---------------------------------------------------------------- assertions
  `CSC_ASSERT_NOW(a_err_zeroes, out_valid && out_data.range_error,
    out_data.seconds_out == 32'd0 && out_data.weekday == 3'd0 &&
    out_data.month_out == 4'd0 && out_data.day_out == 5'd0,
    "error item carries nonzero fields")
  `CSC_ASSERT_NOW(a_unix_sum, out_valid && !out_data.range_error,
    out_data.unix_seconds == out_data.seconds_out + UNIX_OFFSET,
    "unix time does not match seconds count")
  `CSC_ASSERT_NOW(a_date_range, out_valid && !out_data.range_error,
    out_data.weekday <= 3'd6 && out_data.month_out >= 4'd1 &&
    out_data.month_out <= 4'd12 && out_data.day_out >= 5'd1,
    "date fields out of range")
  `CSC_ASSERT_NEXT(a_hold_valids, rst_n && !pipe_en, vld_r == $past(vld_r),
    "stage valid bits moved during a stall")

endmodule

`default_nettype wire

// File: bench/tb_top.sv
// Self-checking bench for calendar_seconds_converter_unit: directed and random date/seconds items.
// Depends on csc_pkg for the item structs and range constants; predicts every result locally.
`timescale 1ns / 1ps

module tb_top;
  import csc_pkg::*;

  localparam int unsigned MONTH_LENGTHS [12] = '{31, 28, 31, 30, 31, 30, 31, 31, 30, 31, 30, 31};
  localparam int unsigned LAST_DAY       = 36524;  // 2099-12-31 as days since the epoch
  localparam int          DIRECTED_ITEMS = 25;
  localparam int          RANDOM_ITEMS   = 1300;
  localparam int          SECOND_DRAIN   = 900;
  localparam int          CALM_FIRST     = 500;
  localparam int          CALM_LAST      = 800;
  localparam int          IDLE_PERCENT   = 26;
  localparam int          QUIET_LIMIT    = 4000;
  localparam int          TAIL_CYCLES    = 20;
  localparam int          REPORT_LIMIT   = 10;
  localparam int          IN_BITS        = $bits(csc_in_t);

  logic     clk       = 1'b0;
  logic     rst_n     = 1'b0;
  logic     in_valid  = 1'b0;
  logic     in_ready;
  csc_in_t  in_data   = '0;
  logic     out_valid;
  logic     out_ready = 1'b0;
  csc_out_t out_data;

  // Items waiting to be presented, and the conversions they must produce, oldest first.
  csc_in_t  items_to_send [$];
  csc_out_t results_due [$];

  int issued_count   = 0;  // items presented on the input channel (driver only)
  int recv_count     = 0;  // results taken from the output channel (nonblocking)
  int mismatch_count = 0;
  int quiet_cycles   = 0;  // cycles since the last handshake on either channel

  calendar_seconds_converter_unit uut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
  );

  always #5 clk = ~clk;

  // Length of a month in a given year since 2000; zero for a month number outside 1..12.
  function automatic int unsigned month_length(input int unsigned yr, input int unsigned mon);
    int unsigned n;
    n = 0;
    if (mon >= 1 && mon <= 12) begin
      n = MONTH_LENGTHS[mon - 1];
      if (mon == 2 && (yr % 4) == 0) begin
        n = n + 1;
      end
    end
    return n;
  endfunction

  // Expected conversion of one item, in either direction.
  function automatic csc_out_t calc_conversion(input csc_in_t it);
    csc_out_t    r;
    int unsigned yr, mon, dy, hr, mi, se, secs, days, rem, k;
    bit          bad;
    r    = '0;
    bad  = 1'b0;
    yr   = 0;
    mon  = 0;
    dy   = 0;
    hr   = 0;
    mi   = 0;
    se   = 0;
    secs = 0;
    days = 0;
    if (it.func == 1'b0) begin
      yr  = it.year_in;
      mon = it.month_in;
      dy  = it.day_in;
      hr  = it.hour_in;
      mi  = it.minute_in;
      se  = it.second_in;
      if (yr > 99 || mon < 1 || mon > 12 || hr > 23 || mi > 59 || se > 59) begin
        bad = 1'b1;
      end else if (dy < 1 || dy > month_length(yr, mon)) begin
        bad = 1'b1;
      end
      if (!bad) begin
        // Whole days before this one: months of this year, then whole years with leap days.
        days = dy - 1;
        for (k = 1; k < mon; k++) begin
          days = days + month_length(yr, k);
        end
        days = days + 365 * yr + (yr + 3) / 4;
        secs = days * SEC_PER_DAY + hr * 3600 + mi * 60 + se;
      end
    end else begin
      if (it.seconds_in > SECONDS_MAX) begin
        bad = 1'b1;
      end else begin
        secs = it.seconds_in;
        se   = secs % 60;
        mi   = (secs / 60) % 60;
        hr   = (secs / 3600) % 24;
        days = secs / SEC_PER_DAY;
        rem  = days;
        // Peel off whole years, then whole months of the year found.
        while (yr < 99 && rem >= (((yr % 4) == 0) ? 366 : 365)) begin
          rem = rem - (((yr % 4) == 0) ? 366 : 365);
          yr  = yr + 1;
        end
        mon = 1;
        while (mon < 12 && rem >= month_length(yr, mon)) begin
          rem = rem - month_length(yr, mon);
          mon = mon + 1;
        end
        dy = rem + 1;
      end
    end
    if (bad) begin
      r.range_error = 1'b1;
    end else begin
      r.seconds_out  = secs;
      r.unix_seconds = secs + UNIX_OFFSET;
      r.year_out     = 7'(yr);
      r.month_out    = 4'(mon);
      r.day_out      = 5'(dy);
      r.hour_out     = 5'(hr);
      r.minute_out   = 6'(mi);
      r.second_out   = 6'(se);
      r.weekday      = 3'((days + 6) % 7);  // the epoch fell on a Saturday
    end
    return r;
  endfunction

  // Queue a date-to-seconds item; the seconds field is noise the block must ignore.
  task automatic add_date(input int unsigned y, input int unsigned m, input int unsigned d,
                          input int unsigned h, input int unsigned mi, input int unsigned s);
    csc_in_t it;
    it.func       = 1'b0;
    it.year_in    = 7'(y);
    it.month_in   = 4'(m);
    it.day_in     = 5'(d);
    it.hour_in    = 5'(h);
    it.minute_in  = 6'(mi);
    it.second_in  = 6'(s);
    it.seconds_in = $urandom;
    items_to_send.push_back(it);
  endtask

  // Queue a seconds-to-date item; the date fields are noise the block must ignore.
  task automatic add_secs(input logic [31:0] t);
    csc_in_t it;
    it = IN_BITS'({$urandom, $urandom, $urandom});
    it.func       = 1'b1;
    it.seconds_in = t;
    items_to_send.push_back(it);
  endtask

  // Driver: present the next item once the previous one is taken. Idle at random outside
  // the calm stretch, and hold off at the drain points until every result is back.
  always @(posedge clk) begin : item_driver
    logic    next_valid;
    csc_in_t next_data;
    logic    drain_hold;
    next_valid = in_valid;
    next_data  = in_data;
    if (!rst_n) begin
      next_valid = 1'b0;
    end else begin
      if (in_valid && in_ready) begin
        next_valid = 1'b0;
      end
      drain_hold = (issued_count == DIRECTED_ITEMS || issued_count == SECOND_DRAIN) &&
                   (recv_count != issued_count);
      if (!next_valid && items_to_send.size() > 0 && !drain_hold) begin
        if ((issued_count >= CALM_FIRST && issued_count < CALM_LAST) ||
            $urandom_range(0, 99) >= IDLE_PERCENT) begin
          next_data  = items_to_send.pop_front();
          next_valid = 1'b1;
          // Predict at issue: valid stays up until the item is taken.
          results_due.push_back(calc_conversion(next_data));
          issued_count = issued_count + 1;
        end
      end
    end
    in_valid <= next_valid;
    in_data  <= next_data;
  end

  // Monitor: take each result, compare it field by field with the oldest prediction,
  // and stall the output channel at random outside the calm stretch.
  always @(posedge clk) begin : result_monitor
    csc_out_t want;
    logic     differs;
    if (!rst_n) begin
      out_ready <= 1'b0;
    end else begin
      if (out_valid && out_ready) begin
        recv_count <= recv_count + 1;
        if (results_due.size() == 0) begin
          mismatch_count = mismatch_count + 1;
          if (mismatch_count <= REPORT_LIMIT) begin
            $display("result %0d arrived with no item outstanding: sec=%0d err=%0b",
                     recv_count, out_data.seconds_out, out_data.range_error);
          end
        end else begin
          want    = results_due.pop_front();
          differs = (out_data.seconds_out  !== want.seconds_out)  ||
                    (out_data.unix_seconds !== want.unix_seconds) ||
                    (out_data.year_out     !== want.year_out)     ||
                    (out_data.month_out    !== want.month_out)    ||
                    (out_data.day_out      !== want.day_out)      ||
                    (out_data.hour_out     !== want.hour_out)     ||
                    (out_data.minute_out   !== want.minute_out)   ||
                    (out_data.second_out   !== want.second_out)   ||
                    (out_data.weekday      !== want.weekday)      ||
                    (out_data.range_error  !== want.range_error);
          if (differs) begin
            mismatch_count = mismatch_count + 1;
            if (mismatch_count <= REPORT_LIMIT) begin
              $write("result %0d mismatch: expected sec=%0d unix=%0d %0d-%0d-%0d ",
                     recv_count, want.seconds_out, want.unix_seconds, want.year_out,
                     want.month_out, want.day_out);
              $write("%0d:%0d:%0d wd=%0d err=%0b, ", want.hour_out, want.minute_out,
                     want.second_out, want.weekday, want.range_error);
              $write("got sec=%0d unix=%0d %0d-%0d-%0d ", out_data.seconds_out,
                     out_data.unix_seconds, out_data.year_out, out_data.month_out,
                     out_data.day_out);
              $display("%0d:%0d:%0d wd=%0d err=%0b", out_data.hour_out,
                       out_data.minute_out, out_data.second_out, out_data.weekday,
                       out_data.range_error);
            end
          end
        end
      end
      out_ready <= (recv_count >= CALM_FIRST && recv_count < CALM_LAST) ||
                   ($urandom_range(0, 99) >= IDLE_PERCENT);
    end
  end

  // Watchdog: count cycles without a handshake on either channel.
  always @(posedge clk) begin
    if (!rst_n || (in_valid && in_ready) || (out_valid && out_ready)) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  initial begin : stimulus_and_finish
    int unsigned y, m, len, pick, day_num;
    csc_in_t     it;
    bit          timed_out;

    // Extremes of the date fields, leap days and every out-of-range case.
    add_date(0, 1, 1, 0, 0, 0);
    add_date(99, 12, 31, 23, 59, 59);
    add_date(0, 2, 29, 12, 30, 30);
    add_date(1, 2, 29, 0, 0, 0);
    add_date(1, 2, 28, 23, 59, 59);
    add_date(4, 3, 1, 0, 0, 0);
    add_date(5, 1, 0, 0, 0, 0);
    add_date(5, 4, 31, 0, 0, 0);
    add_date(5, 4, 30, 6, 7, 8);
    add_date(10, 0, 1, 0, 0, 0);
    add_date(10, 13, 1, 0, 0, 0);
    add_date(10, 15, 31, 0, 0, 0);
    add_date(100, 1, 1, 0, 0, 0);
    add_date(127, 12, 31, 23, 59, 59);
    add_date(20, 6, 15, 24, 0, 0);
    add_date(20, 6, 15, 31, 63, 63);
    add_date(20, 6, 15, 0, 60, 0);
    add_date(20, 6, 15, 0, 0, 60);
    // Seconds: epoch, last valid second, just past it, all ones, leap-year boundaries.
    add_secs(32'd0);
    add_secs(SECONDS_MAX);
    add_secs(SECONDS_MAX + 32'd1);
    add_secs(32'hFFFF_FFFF);
    add_secs(32'd59 * SEC_PER_DAY);
    add_secs(32'd366 * SEC_PER_DAY - 32'd1);
    add_secs(32'd366 * SEC_PER_DAY);

    // Random part: mostly well-formed dates and in-range counts, some raw noise.
    repeat (RANDOM_ITEMS) begin
      pick = $urandom_range(0, 99);
      if (pick < 35) begin
        y = $urandom_range(0, 99);
        m = $urandom_range(1, 12);
        add_date(y, m, $urandom_range(1, month_length(y, m)), $urandom_range(0, 23),
                 $urandom_range(0, 59), $urandom_range(0, 59));
      end else if (pick < 45) begin
        it      = IN_BITS'({$urandom, $urandom, $urandom});
        it.func = 1'b0;
        items_to_send.push_back(it);
      end else if (pick < 50) begin
        // Last day of a month, or one past it.
        y   = $urandom_range(0, 99);
        m   = $urandom_range(1, 12);
        len = month_length(y, m) + $urandom_range(0, 1);
        add_date(y, m, len, $urandom_range(0, 23), $urandom_range(0, 59),
                 $urandom_range(0, 59));
      end else if (pick < 80) begin
        add_secs($urandom_range(0, SECONDS_MAX));
      end else if (pick < 90) begin
        // First or last second of a random day.
        day_num = $urandom_range(0, LAST_DAY);
        add_secs(day_num * SEC_PER_DAY + (($urandom_range(0, 1) == 1) ? 86399 : 0));
      end else if (pick < 95) begin
        add_secs(SECONDS_MAX - 32'd8 + 32'($urandom_range(0, 16)));
      end else begin
        add_secs($urandom);
      end
    end

    // Hold reset, then release it on a rising edge.
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;

    // Wait until every item is taken and every result has come back, or the watchdog trips.
    timed_out = 1'b0;
    @(negedge clk);
    while (!timed_out &&
           !(items_to_send.size() == 0 && !in_valid && results_due.size() == 0)) begin
      if (quiet_cycles >= QUIET_LIMIT) begin
        timed_out = 1'b1;
      end
      @(negedge clk);
    end

    if (timed_out) begin
      $display("end of test: mismatches");
    end else begin
      // Keep watching the output after the drain so any stray result is caught.
      repeat (TAIL_CYCLES) @(negedge clk);
      if (mismatch_count == 0 && results_due.size() == 0) begin
        $display("end of test: clean");
      end else begin
        $display("end of test: mismatches");
      end
    end
    $finish;
  end

endmodule
